@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define XMT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication form of the same.
`define XMT_ASSERT_IMP(label, clk, rstn, pre, post, msg) \
  `XMT_ASSERT(label, clk, rstn, (pre) |-> (post), msg)

// Next-cycle implication form.
`define XMT_ASSERT_NXT(label, clk, rstn, pre, post, msg) \
  `XMT_ASSERT(label, clk, rstn, (pre) |=> (post), msg)

`endif

@@ rtl/core/xmt_pkg.sv @@
// Package of the XML markup tokenizer: modes, event kinds, characters, types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package xmt_pkg;

  localparam int unsigned KindW  = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [ModeW-1:0] MODE_TEXT  = 2'd0;
  localparam logic [ModeW-1:0] MODE_NAME  = 2'd1;
  localparam logic [ModeW-1:0] MODE_ATTR  = 2'd2;
  localparam logic [ModeW-1:0] MODE_VALUE = 2'd3;

  localparam logic [KindW-1:0] EV_TEXT_CHAR  = 4'd0;
  localparam logic [KindW-1:0] EV_NAME_CHAR  = 4'd1;
  localparam logic [KindW-1:0] EV_ATTR_CHAR  = 4'd2;
  localparam logic [KindW-1:0] EV_VALUE_CHAR = 4'd3;
  localparam logic [KindW-1:0] EV_TEXT_END   = 4'd4;
  localparam logic [KindW-1:0] EV_NAME_END   = 4'd5;
  localparam logic [KindW-1:0] EV_ATTR_END   = 4'd6;
  localparam logic [KindW-1:0] EV_VALUE_END  = 4'd7;
  localparam logic [KindW-1:0] EV_ELEM_END   = 4'd8;
  localparam logic [KindW-1:0] EV_DOC_END    = 4'd9;
  localparam logic [KindW-1:0] EV_MALFORMED  = 4'd10;

  localparam logic [ByteW-1:0] CH_LT    = 8'h3C;
  localparam logic [ByteW-1:0] CH_GT    = 8'h3E;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2F;
  localparam logic [ByteW-1:0] CH_EQ    = 8'h3D;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic             incomplete;
  } event_t;

  // One input item's worth of events: one or two.
  typedef struct packed {
    logic   two;
    event_t ev0;
    event_t ev1;
  } packet_t;

endpackage

@@ rtl/core/xmt_front.sv @@
// Front end: accepts input items, tracks the parse mode and classifies bytes.
// Depends on xmt_pkg; pushes event packets into xmt_queue.
`timescale 1ns / 1ps

module xmt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [xmt_pkg::ByteW-1:0]   char_byte_i,
  input  logic                        full_i,
  output logic                        push_o,
  output xmt_pkg::packet_t            pkt_o
);

  logic [xmt_pkg::ModeW-1:0] mode_q, mode_d;
  logic                      quote_q, quote_d;
  logic                      pend_q, pend_d;
  logic                      has_ev;
  logic                      accept;
  xmt_pkg::packet_t          pkt;

  function automatic xmt_pkg::event_t mk_ev(logic [xmt_pkg::KindW-1:0] kind,
                                            logic [xmt_pkg::ByteW-1:0] data,
                                            logic inc);
    xmt_pkg::event_t e;
    e.kind       = kind;
    e.data       = data;
    e.incomplete = inc;
    return e;
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [xmt_pkg::KindW-1:0] char_kind;
    logic [xmt_pkg::KindW-1:0] end_kind;
    char_kind = {2'b00, mode_q};
    end_kind  = {2'b01, mode_q};
    mode_d  = mode_q;
    quote_d = quote_q;
    pend_d  = pend_q;
    has_ev  = 1'b0;
    pkt     = '0;
    if (cmd_i == xmt_pkg::CMD_END) begin
      has_ev = 1'b1;
      if (pend_q) begin
        pkt.two = 1'b1;
        pkt.ev0 = mk_ev(xmt_pkg::EV_TEXT_END, '0, 1'b0);
        pkt.ev1 = mk_ev(xmt_pkg::EV_DOC_END, '0, mode_q != xmt_pkg::MODE_TEXT);
      end else begin
        pkt.ev0 = mk_ev(xmt_pkg::EV_DOC_END, '0, mode_q != xmt_pkg::MODE_TEXT);
      end
      mode_d  = xmt_pkg::MODE_TEXT;
      quote_d = 1'b0;
      pend_d  = 1'b0;
    end else if (mode_q == xmt_pkg::MODE_TEXT) begin
      if (char_byte_i == xmt_pkg::CH_LT) begin
        has_ev  = pend_q;
        pkt.ev0 = mk_ev(xmt_pkg::EV_TEXT_END, '0, 1'b0);
        pend_d  = 1'b0;
        quote_d = 1'b0;
        mode_d  = xmt_pkg::MODE_NAME;
      end else begin
        has_ev  = 1'b1;
        pkt.ev0 = mk_ev(xmt_pkg::EV_TEXT_CHAR, char_byte_i, 1'b0);
        pend_d  = 1'b1;
      end
    end else if (char_byte_i == xmt_pkg::CH_LT) begin
      has_ev  = 1'b1;
      pkt.ev0 = mk_ev(xmt_pkg::EV_MALFORMED, '0, 1'b0);
    end else if (char_byte_i == xmt_pkg::CH_QUOTE) begin
      quote_d = !quote_q;
    end else if (quote_q) begin
      has_ev  = (char_byte_i != xmt_pkg::CH_GT) && (char_byte_i != xmt_pkg::CH_SLASH)
                && (char_byte_i != xmt_pkg::CH_EQ);
      pkt.ev0 = mk_ev(char_kind, char_byte_i, 1'b0);
    end else begin
      unique case (mode_q)
        xmt_pkg::MODE_NAME: begin
          if (char_byte_i == xmt_pkg::CH_SPACE) begin
            has_ev  = 1'b1;
            pkt.ev0 = mk_ev(end_kind, '0, 1'b0);
            mode_d  = xmt_pkg::MODE_ATTR;
          end else if (char_byte_i == xmt_pkg::CH_GT) begin
            has_ev  = 1'b1;
            pkt.two = 1'b1;
            pkt.ev0 = mk_ev(end_kind, '0, 1'b0);
            pkt.ev1 = mk_ev(xmt_pkg::EV_ELEM_END, '0, 1'b0);
            mode_d  = xmt_pkg::MODE_TEXT;
          end else begin
            has_ev  = char_byte_i != xmt_pkg::CH_EQ;
            pkt.ev0 = mk_ev(char_kind, char_byte_i, 1'b0);
          end
        end
        xmt_pkg::MODE_ATTR: begin
          if (char_byte_i == xmt_pkg::CH_EQ) begin
            has_ev  = 1'b1;
            pkt.ev0 = mk_ev(end_kind, '0, 1'b0);
            mode_d  = xmt_pkg::MODE_VALUE;
          end else if (char_byte_i == xmt_pkg::CH_GT) begin
            has_ev  = 1'b1;
            pkt.ev0 = mk_ev(xmt_pkg::EV_ELEM_END, '0, 1'b0);
            mode_d  = xmt_pkg::MODE_TEXT;
          end else begin
            has_ev  = (char_byte_i != xmt_pkg::CH_SPACE)
                      && (char_byte_i != xmt_pkg::CH_SLASH);
            pkt.ev0 = mk_ev(char_kind, char_byte_i, 1'b0);
          end
        end
        default: begin
          if ((char_byte_i == xmt_pkg::CH_SPACE) || (char_byte_i == xmt_pkg::CH_SLASH)) begin
            has_ev  = 1'b1;
            pkt.ev0 = mk_ev(end_kind, '0, 1'b0);
            mode_d  = xmt_pkg::MODE_ATTR;
          end else if (char_byte_i == xmt_pkg::CH_GT) begin
            has_ev  = 1'b1;
            pkt.two = 1'b1;
            pkt.ev0 = mk_ev(end_kind, '0, 1'b0);
            pkt.ev1 = mk_ev(xmt_pkg::EV_ELEM_END, '0, 1'b0);
            mode_d  = xmt_pkg::MODE_TEXT;
          end else begin
            has_ev  = char_byte_i != xmt_pkg::CH_EQ;
            pkt.ev0 = mk_ev(char_kind, char_byte_i, 1'b0);
          end
        end
      endcase
    end
  end

  assign push_o = accept && has_ev;
  assign pkt_o  = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= xmt_pkg::MODE_TEXT;
      quote_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      pend_q  <= pend_d;
    end
  end

endmodule

@@ rtl/core/xmt_queue.sv @@
// Two-entry queue of event packets between the front and the back end.
// Depends on xmt_pkg.
`timescale 1ns / 1ps

module xmt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xmt_pkg::packet_t pkt_i,
  output logic             full_o,
  output logic             head_valid_o,
  output xmt_pkg::packet_t head_o,
  input  logic             pop_i
);

  xmt_pkg::packet_t                mem_q [xmt_pkg::QDepth];
  logic [xmt_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [xmt_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o       = cnt_q == xmt_pkg::QCntW'(xmt_pkg::QDepth);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

endmodule

@@ rtl/core/xmt_back.sv @@
// Back end: splits each packet into single events and holds the output register.
// Depends on xmt_pkg; drains xmt_queue.
`timescale 1ns / 1ps

module xmt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  xmt_pkg::packet_t          head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [xmt_pkg::KindW-1:0] event_kind_o,
  output logic [xmt_pkg::ByteW-1:0] event_byte_o,
  output logic                      doc_incomplete_o,
  output logic                      last_of_run_o
);

  logic            valid_q, valid_d;
  logic            second_q, second_d;
  logic            load;
  xmt_pkg::event_t ev_q, ev_d;
  logic            last_q, last_d;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    ev_d     = ev_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (second_q) begin
          ev_d     = head_i.ev1;
          last_d   = 1'b1;
          pop_o    = 1'b1;
          second_d = 1'b0;
        end else begin
          ev_d     = head_i.ev0;
          last_d   = !head_i.two;
          pop_o    = !head_i.two;
          second_d = head_i.two;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    last_q <= last_d;
  end

  assign out_valid_o      = valid_q;
  assign event_kind_o     = ev_q.kind;
  assign event_byte_o     = ev_q.data;
  assign doc_incomplete_o = ev_q.incomplete;
  assign last_of_run_o    = last_q;

endmodule

@@ rtl/core/xml_markup_tokenizer.sv @@
// XML markup tokenizer: one document byte or end-of-document item per cycle while not stalled.
// An accepted request's events pass through the packet queue into the output register.
// An item with two events loads the output register once for each of its events in turn.
// The two-entry packet queue absorbs those pairs, so input stalls only when it fills.
// Reset clears the parse mode, quote and pending-text flags, the queue and the output valid.
`timescale 1ns / 1ps

module xml_markup_tokenizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [xmt_pkg::ByteW-1:0] char_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [xmt_pkg::KindW-1:0] event_kind_o,
  output logic [xmt_pkg::ByteW-1:0] event_byte_o,
  output logic                      doc_incomplete_o,
  output logic                      last_of_run_o
);

  logic             push, full, head_valid, pop;
  xmt_pkg::packet_t pkt, head;

  xmt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .char_byte_i (char_byte_i),
    .full_i      (full),
    .push_o      (push),
    .pkt_o       (pkt)
  );

  xmt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pkt_i        (pkt),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  xmt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .event_byte_o     (event_byte_o),
    .doc_incomplete_o (doc_incomplete_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

@@ rtl/core/xmt_checker.sv @@
// Port-level checker for the XML markup tokenizer, bound to the top level.
// Depends on xmt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xmt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [xmt_pkg::KindW-1:0] event_kind_o,
  input logic [xmt_pkg::ByteW-1:0] event_byte_o,
  input logic                      doc_incomplete_o,
  input logic                      last_of_run_o
);

  `XMT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(event_kind_o) && $stable(event_byte_o), "Output request dropped or changed while stalled.")
  `XMT_ASSERT_IMP(a_marker_zero_byte, clk_i, rst_ni, out_valid_o && (event_kind_o > xmt_pkg::EV_VALUE_CHAR), event_byte_o == '0, "Marker event carries a nonzero byte.")
  `XMT_ASSERT_IMP(a_incomplete_doc_only, clk_i, rst_ni, out_valid_o && doc_incomplete_o, event_kind_o == xmt_pkg::EV_DOC_END, "Incomplete flag set on an event other than document end.")
  `XMT_ASSERT_IMP(a_doc_end_last, clk_i, rst_ni, out_valid_o && (event_kind_o == xmt_pkg::EV_DOC_END), last_of_run_o, "Document end is not the last event of its item.")

endmodule

bind xml_markup_tokenizer xmt_checker u_xmt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .event_kind_o     (event_kind_o),
  .event_byte_o     (event_byte_o),
  .doc_incomplete_o (doc_incomplete_o),
  .last_of_run_o    (last_of_run_o)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the XML markup tokenizer: directed and random documents.
// Predicts the event stream of each request and compares every accepted event in order.
// Depends on xmt_pkg and the xml_markup_tokenizer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StreamLen   = 1120;

  typedef struct packed {
    logic                      cmd;
    logic [xmt_pkg::ByteW-1:0] ch;
  } doc_item_t;

  typedef struct packed {
    logic [xmt_pkg::KindW-1:0] kind;
    logic [xmt_pkg::ByteW-1:0] data;
    logic                      incomplete;
    logic                      last;
  } tok_event_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      cmd_i = xmt_pkg::CMD_BYTE;
  logic [xmt_pkg::ByteW-1:0] char_byte_i = '0;
  logic                      out_ready_i = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [xmt_pkg::KindW-1:0] event_kind_o;
  logic [xmt_pkg::ByteW-1:0] event_byte_o;
  logic                      doc_incomplete_o;
  logic                      last_of_run_o;

  doc_item_t        input_stream[$];
  tok_event_t       expected_events[$];

  logic [xmt_pkg::ModeW-1:0] tok_mode = xmt_pkg::MODE_TEXT;
  logic             tok_quoted = 1'b0;
  logic             tok_text_open = 1'b0;

  logic             in_fire = 1'b0;
  logic             out_fire = 1'b0;
  logic             hold_off = 1'b0;
  logic             send_idle = 1'b1;
  logic             recv_idle = 1'b1;
  int unsigned      send_gap = 0;
  int unsigned      recv_wait = 0;
  int unsigned      cycle_count = 0;
  int unsigned      accepted_items = 0;
  int unsigned      checked_events = 0;
  int unsigned      malformed_events = 0;
  int unsigned      doc_count = 0;
  int unsigned      mismatch_count = 0;

  xml_markup_tokenizer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .char_byte_i      (char_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .event_byte_o     (event_byte_o),
    .doc_incomplete_o (doc_incomplete_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Event prediction.

  function automatic void queue_event(input logic [xmt_pkg::KindW-1:0] kind,
                                      input logic [xmt_pkg::ByteW-1:0] data,
                                      input logic incomplete);
    tok_event_t ev;
    ev.kind       = kind;
    ev.data       = data;
    ev.incomplete = incomplete;
    ev.last       = 1'b0;
    expected_events.push_back(ev);
  endfunction

  function automatic void predict_events(input logic cmd,
                                         input logic [xmt_pkg::ByteW-1:0] ch);
    int unsigned               base;
    logic [xmt_pkg::KindW-1:0] char_kind;
    logic [xmt_pkg::KindW-1:0] end_kind;
    base = expected_events.size();
    case (tok_mode)
      xmt_pkg::MODE_NAME: begin
        char_kind = xmt_pkg::EV_NAME_CHAR;
        end_kind  = xmt_pkg::EV_NAME_END;
      end
      xmt_pkg::MODE_ATTR: begin
        char_kind = xmt_pkg::EV_ATTR_CHAR;
        end_kind  = xmt_pkg::EV_ATTR_END;
      end
      xmt_pkg::MODE_VALUE: begin
        char_kind = xmt_pkg::EV_VALUE_CHAR;
        end_kind  = xmt_pkg::EV_VALUE_END;
      end
      default: begin
        char_kind = xmt_pkg::EV_TEXT_CHAR;
        end_kind  = xmt_pkg::EV_TEXT_END;
      end
    endcase
    if (cmd == xmt_pkg::CMD_END) begin
      if (tok_text_open) queue_event(xmt_pkg::EV_TEXT_END, '0, 1'b0);
      queue_event(xmt_pkg::EV_DOC_END, '0, tok_mode != xmt_pkg::MODE_TEXT);
      tok_mode      = xmt_pkg::MODE_TEXT;
      tok_quoted    = 1'b0;
      tok_text_open = 1'b0;
    end else if (tok_mode == xmt_pkg::MODE_TEXT) begin
      if (ch == xmt_pkg::CH_LT) begin
        if (tok_text_open) queue_event(xmt_pkg::EV_TEXT_END, '0, 1'b0);
        tok_text_open = 1'b0;
        tok_quoted    = 1'b0;
        tok_mode      = xmt_pkg::MODE_NAME;
      end else begin
        queue_event(xmt_pkg::EV_TEXT_CHAR, ch, 1'b0);
        tok_text_open = 1'b1;
      end
    end else if (ch == xmt_pkg::CH_LT) begin
      queue_event(xmt_pkg::EV_MALFORMED, '0, 1'b0);
    end else if (ch == xmt_pkg::CH_QUOTE) begin
      tok_quoted = !tok_quoted;
    end else if (tok_quoted) begin
      if (ch != xmt_pkg::CH_GT && ch != xmt_pkg::CH_SLASH && ch != xmt_pkg::CH_EQ) begin
        queue_event(char_kind, ch, 1'b0);
      end
    end else if (tok_mode == xmt_pkg::MODE_NAME) begin
      if (ch == xmt_pkg::CH_SPACE) begin
        queue_event(end_kind, '0, 1'b0);
        tok_mode = xmt_pkg::MODE_ATTR;
      end else if (ch == xmt_pkg::CH_GT) begin
        queue_event(end_kind, '0, 1'b0);
        queue_event(xmt_pkg::EV_ELEM_END, '0, 1'b0);
        tok_mode = xmt_pkg::MODE_TEXT;
      end else if (ch != xmt_pkg::CH_EQ) begin
        queue_event(char_kind, ch, 1'b0);
      end
    end else if (tok_mode == xmt_pkg::MODE_ATTR) begin
      if (ch == xmt_pkg::CH_EQ) begin
        queue_event(end_kind, '0, 1'b0);
        tok_mode = xmt_pkg::MODE_VALUE;
      end else if (ch == xmt_pkg::CH_GT) begin
        queue_event(xmt_pkg::EV_ELEM_END, '0, 1'b0);
        tok_mode = xmt_pkg::MODE_TEXT;
      end else if (ch != xmt_pkg::CH_SPACE && ch != xmt_pkg::CH_SLASH) begin
        queue_event(char_kind, ch, 1'b0);
      end
    end else begin
      if (ch == xmt_pkg::CH_SPACE || ch == xmt_pkg::CH_SLASH) begin
        queue_event(end_kind, '0, 1'b0);
        tok_mode = xmt_pkg::MODE_ATTR;
      end else if (ch == xmt_pkg::CH_GT) begin
        queue_event(end_kind, '0, 1'b0);
        queue_event(xmt_pkg::EV_ELEM_END, '0, 1'b0);
        tok_mode = xmt_pkg::MODE_TEXT;
      end else if (ch != xmt_pkg::CH_EQ) begin
        queue_event(char_kind, ch, 1'b0);
      end
    end
    if (expected_events.size() > base) begin
      expected_events[expected_events.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void note_mismatch(input string what, input tok_event_t exp_ev,
                                        input tok_event_t got_ev);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %0s: kind %0d/%0d byte %02h/%02h incomplete %0b/%0b last %0b/%0b",
               $realtime, what, exp_ev.kind, got_ev.kind, exp_ev.data, got_ev.data,
               exp_ev.incomplete, got_ev.incomplete, exp_ev.last, got_ev.last);
    end
  endfunction

  // Stimulus construction.

  function automatic void add_byte(input logic [xmt_pkg::ByteW-1:0] ch);
    doc_item_t item;
    item.cmd = xmt_pkg::CMD_BYTE;
    item.ch  = ch;
    input_stream.push_back(item);
  endfunction

  function automatic void add_end();
    doc_item_t item;
    item.cmd = xmt_pkg::CMD_END;
    item.ch  = xmt_pkg::ByteW'($urandom_range(0, 255));
    input_stream.push_back(item);
    doc_count++;
  endfunction

  function automatic void add_chars(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [xmt_pkg::ByteW-1:0] pick_char();
    if ($urandom_range(0, 4) == 0) return xmt_pkg::ByteW'($urandom_range(0, 255));
    return xmt_pkg::ByteW'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [xmt_pkg::ByteW-1:0] pick_special();
    case ($urandom_range(0, 5))
      0: return xmt_pkg::CH_LT;
      1: return xmt_pkg::CH_GT;
      2: return xmt_pkg::CH_SLASH;
      3: return xmt_pkg::CH_EQ;
      4: return xmt_pkg::CH_QUOTE;
      default: return xmt_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic void add_random_element();
    add_byte(xmt_pkg::CH_LT);
    if ($urandom_range(0, 3) == 0) add_byte(xmt_pkg::CH_SLASH);
    repeat ($urandom_range(1, 5)) add_byte(pick_char());
    repeat ($urandom_range(0, 3)) begin
      add_byte(xmt_pkg::CH_SPACE);
      repeat ($urandom_range(1, 4)) add_byte(pick_char());
      if ($urandom_range(0, 4) != 0) begin
        add_byte(xmt_pkg::CH_EQ);
        if ($urandom_range(0, 1) == 1) begin
          add_byte(xmt_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            add_byte(($urandom_range(0, 3) == 0) ? pick_special() : pick_char());
          end
          add_byte(xmt_pkg::CH_QUOTE);
        end else begin
          repeat ($urandom_range(1, 4)) add_byte(pick_char());
        end
      end
    end
    if ($urandom_range(0, 3) == 0) add_byte(xmt_pkg::CH_SLASH);
    add_byte(xmt_pkg::CH_GT);
  endfunction

  function automatic void add_random_doc();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 5)) add_byte(pick_char());
        8: repeat ($urandom_range(1, 4)) add_byte(pick_special());
        9: begin
          add_byte(xmt_pkg::CH_LT);
          repeat ($urandom_range(0, 3)) add_byte(pick_char());
          add_end();
        end
        default: add_random_element();
      endcase
    end
    add_end();
  endfunction

  // Request driver and event monitor.

  always @(negedge clk_i) begin : drive_requests
    logic        valid_n;
    int unsigned gap_n;
    doc_item_t   item;
    if (rst_ni) begin
      valid_n = in_valid_i;
      gap_n   = send_gap;
      if (in_fire) valid_n = 1'b0;
      if (!valid_n) begin
        if (gap_n != 0) begin
          gap_n--;
        end else if (input_stream.size() != 0) begin
          item = input_stream.pop_front();
          cmd_i       <= item.cmd;
          char_byte_i <= item.ch;
          valid_n = 1'b1;
          gap_n   = send_idle ? $urandom_range(0, 5) : 0;
          if ($urandom_range(0, 63) == 0) send_idle = !send_idle;
        end
      end
      in_valid_i <= valid_n;
      send_gap   <= gap_n;
    end
  end

  always @(negedge clk_i) begin : drive_ready
    int unsigned wait_n;
    if (rst_ni) begin
      wait_n = recv_wait;
      if (out_fire) begin
        wait_n = recv_idle ? $urandom_range(0, 5) : 0;
        if ($urandom_range(0, 63) == 0) recv_idle = !recv_idle;
      end else if (wait_n != 0) begin
        wait_n--;
      end
      recv_wait   <= wait_n;
      out_ready_i <= !hold_off && wait_n == 0;
    end
  end

  always @(posedge clk_i) begin : monitor
    tok_event_t got_ev;
    tok_event_t exp_ev;
    if (rst_ni) begin
      in_fire  <= in_valid_i && in_ready_o;
      out_fire <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        predict_events(cmd_i, char_byte_i);
        accepted_items <= accepted_items + 1;
      end
      if (out_valid_o && out_ready_i) begin
        got_ev.kind       = event_kind_o;
        got_ev.data       = event_byte_o;
        got_ev.incomplete = doc_incomplete_o;
        got_ev.last       = last_of_run_o;
        checked_events++;
        if (got_ev.kind == xmt_pkg::EV_MALFORMED) malformed_events++;
        if (expected_events.size() == 0) begin
          note_mismatch("event with none expected", '0, got_ev);
        end else begin
          exp_ev = expected_events.pop_front();
          if (got_ev != exp_ev) note_mismatch("event mismatch", exp_ev, got_ev);
        end
      end
    end
  end

  // Long receiver stall so that the internal queue fills and input backs up.
  initial begin
    wait (accepted_items >= 300);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("xml_markup_tokenizer regression: fail");
      $finish;
    end
  end

  initial begin
    // Text extremes, a quote in text, quoted markup, every mode change,
    // a misplaced open bracket, and document ends in each situation.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_chars("\"</=\"> \" /=v/<>< = =><>x");
    add_end();
    add_chars("<");
    add_end();
    add_end();
    while (input_stream.size() < StreamLen) add_random_doc();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    while (input_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d requests in %0d documents, including a long output stall.",
             accepted_items, doc_count);
    $display("Checked %0d events (%0d malformed markers), %0d mismatches.",
             checked_events, malformed_events, mismatch_count);
    if (mismatch_count == 0) begin
      $display("xml_markup_tokenizer regression: pass");
    end else begin
      $display("xml_markup_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/xmt_pkg.sv
rtl/core/xmt_front.sv
rtl/core/xmt_queue.sv
rtl/core/xmt_back.sv
rtl/core/xml_markup_tokenizer.sv
rtl/core/xmt_checker.sv
tb/sv/tb_top.sv
